[src/ojt_pkg.sv]
// Shared types and codes for the ordered job table.
package ojt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int COUNT_W         = 5;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_NO_MATCH = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [15:0] time_in;
        logic [7:0]  pickup;
        logic [7:0]  dropoff;
        logic [7:0]  item_type;
        logic [15:0] perish_time;
    } job_rec_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        status_t  status;
        logic     found;
        job_rec_t rec;
    } result_t;

endpackage

[src/ojt_store.sv]
// Record memory: one write port and one read port with registered read data.
module ojt_store #(
    parameter int TABLE_DEPTH = ojt_pkg::TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic             clk,
    input  ojt_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]    wr_addr,
    input  ojt_pkg::job_rec_t wr_data,
    input  logic [AW-1:0]    rd_addr,
    output ojt_pkg::job_rec_t rd_data
);

    ojt_pkg::job_rec_t mem [TABLE_DEPTH];
    ojt_pkg::job_rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/ojt_seq.sv]
// Sequencer: walks the table through the shared compare unit, shifts on removal.
module ojt_seq #(
    parameter int TABLE_DEPTH = ojt_pkg::TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         in_action,
    input  ojt_pkg::job_rec_t  in_rec,
    output logic               out_valid,
    input  logic               out_stall,
    output ojt_pkg::result_t   out_res,
    output logic [CW-1:0]      out_count,
    output ojt_pkg::mem_ctl_t  mem_ctl,
    output logic [AW-1:0]      wr_addr,
    output ojt_pkg::job_rec_t  wr_data,
    output logic [AW-1:0]      rd_addr,
    input  ojt_pkg::job_rec_t  rd_data
);

    ojt_pkg::state_t   state_reg, state_next;
    logic [1:0]        act_reg, act_next;
    ojt_pkg::job_rec_t req_reg, req_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [AW-1:0]     chk_idx_reg, chk_idx_next;
    logic [AW-1:0]     dst_reg, dst_next;
    logic              pend_reg, pend_next;
    ojt_pkg::result_t  res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    ojt_pkg::result_t  out_res_reg, out_res_next;
    logic [CW-1:0]     out_count_reg, out_count_next;
    logic              hit;
    logic              accept;

    assign in_stall = (state_reg != ojt_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // shared compare unit
    always_comb
    begin
        if (act_reg == ojt_pkg::ACT_REMOVE)
        begin
            hit = (rd_data.time_in == req_reg.time_in) && (rd_data.pickup == req_reg.pickup)
                && (rd_data.dropoff == req_reg.dropoff)
                && (rd_data.item_type == req_reg.item_type);
        end
        else
        begin
            hit = (rd_data.pickup == req_reg.pickup);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ojt_pkg::ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        req_reg       <= req_next;
        ptr_reg       <= ptr_next;
        chk_idx_reg   <= chk_idx_next;
        dst_reg       <= dst_next;
        res_reg       <= res_next;
        out_res_reg   <= out_res_next;
        out_count_reg <= out_count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        req_next       = req_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        dst_next       = dst_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_res_next   = out_res_reg;
        out_count_next = out_count_reg;
        mem_ctl        = '0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = req_reg;
        rd_addr        = ptr_reg[AW-1:0];

        unique case (state_reg)
            ojt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    act_next       = in_action;
                    req_next       = in_rec;
                    ptr_next       = '0;
                    chk_valid_next = 1'b0;
                    pend_next      = 1'b0;
                    res_next       = '0;
                    if (in_action == ojt_pkg::ACT_APPEND)
                    begin
                        state_next = ojt_pkg::ST_APPEND;
                    end
                    else if (in_action == ojt_pkg::ACT_REMOVE || in_action == ojt_pkg::ACT_QUERY)
                    begin
                        state_next = ojt_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = ojt_pkg::ST_FINISH;
                    end
                end
            end

            ojt_pkg::ST_APPEND:
            begin
                if (count_reg >= CW'(TABLE_DEPTH))
                begin
                    res_next.status = ojt_pkg::STATUS_FULL;
                end
                else
                begin
                    mem_ctl.wr_en = 1'b1;
                    count_next    = count_reg + 1'b1;
                end
                state_next = ojt_pkg::ST_FINISH;
            end

            ojt_pkg::ST_SCAN:
            begin
                if (chk_valid_reg && hit)
                begin
                    chk_valid_next = 1'b0;
                    if (act_reg == ojt_pkg::ACT_REMOVE)
                    begin
                        res_next.rec = rd_data;
                        ptr_next     = CW'(chk_idx_reg) + 1'b1;
                        pend_next    = 1'b0;
                        state_next   = ojt_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        res_next.found = 1'b1;
                        state_next     = ojt_pkg::ST_FINISH;
                    end
                end
                else if (ptr_reg < count_reg)
                begin
                    mem_ctl.rd_en  = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = ptr_reg[AW-1:0];
                    ptr_next       = ptr_reg + 1'b1;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                    if (act_reg == ojt_pkg::ACT_REMOVE)
                    begin
                        res_next.status = ojt_pkg::STATUS_NO_MATCH;
                    end
                    state_next = ojt_pkg::ST_FINISH;
                end
            end

            ojt_pkg::ST_SHIFT:
            begin
                // write back the entry read last cycle one place toward the head
                wr_addr = dst_reg;
                wr_data = rd_data;
                mem_ctl.wr_en = pend_reg;
                if (ptr_reg < count_reg)
                begin
                    mem_ctl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    dst_next      = AW'(ptr_reg - 1'b1);
                    ptr_next      = ptr_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - 1'b1;
                    state_next = ojt_pkg::ST_FINISH;
                end
            end

            ojt_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg;
                    out_count_next = count_reg;
                    state_next     = ojt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ojt_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_count = out_count_reg;

endmodule

[src/ordered_job_table.sv]
// Ordered job table top level: append, keyed remove and pickup query.
//
//  channel  direction  handshake            payload
//  input    in         in_valid/in_stall    action, time_in, pickup, dropoff, item_type,
//                                           perish_time
//  output   out        out_valid/out_stall  status, found, removed_*, entry_count
//
// Query and remove walk the table through one compare unit, one entry a cycle, each compared
// in the cycle after its registered read; a removal then shifts later entries, one per cycle
// over the single write port. Input stalls while an item is in flight; a finished result
// waits in the output register and the next item may be taken meanwhile.
// Reset clears the count and control state; the record memory needs no clearing.
module ordered_job_table #(
    parameter int TABLE_DEPTH = ojt_pkg::TABLE_DEPTH_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] time_in,
    input  logic [7:0]  pickup,
    input  logic [7:0]  dropoff,
    input  logic [7:0]  item_type,
    input  logic [15:0] perish_time,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic [15:0] removed_time_in,
    output logic [7:0]  removed_pickup,
    output logic [7:0]  removed_dropoff,
    output logic [7:0]  removed_item_type,
    output logic [15:0] removed_perish_time,
    output logic [4:0]  entry_count
);

    ojt_pkg::job_rec_t in_rec;
    ojt_pkg::job_rec_t wr_data;
    ojt_pkg::job_rec_t rd_data;
    ojt_pkg::mem_ctl_t mem_ctl;
    ojt_pkg::result_t  out_res;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     out_count;

    assign in_rec.time_in     = time_in;
    assign in_rec.pickup      = pickup;
    assign in_rec.dropoff     = dropoff;
    assign in_rec.item_type   = item_type;
    assign in_rec.perish_time = perish_time;

    ojt_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_action (action),
        .in_rec    (in_rec),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res),
        .out_count (out_count),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    ojt_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign status              = out_res.status;
    assign found               = out_res.found;
    assign removed_time_in     = out_res.rec.time_in;
    assign removed_pickup      = out_res.rec.pickup;
    assign removed_dropoff     = out_res.rec.dropoff;
    assign removed_item_type   = out_res.rec.item_type;
    assign removed_perish_time = out_res.rec.perish_time;
    assign entry_count         = 5'(out_count);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a transaction is in flight");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ojt_pkg::STATUS_FULL) |-> (out_count == CW'(TABLE_DEPTH)))
        else $error("full status with table not full");

    a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ojt_pkg::STATUS_NO_MATCH) |->
        (removed_time_in == '0 && removed_perish_time == '0 && !found))
        else $error("no-match result carries record data");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == ojt_pkg::STATUS_OK))
        else $error("query hit with error status");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the ordered job table: queued stimulus, predicted results.
module testbench;

    localparam int         DEPTH        = 16;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 2000;
    localparam int         TAIL_ITEMS   = 200;
    localparam int         LONG_HOLD    = 400;
    localparam int         LONG_HOLD_AT = 600;
    localparam int         SETTLE       = 100;
    localparam int         CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [1:0]        act;
        ojt_pkg::job_rec_t rec;
    } job_req_t;

    typedef struct packed {
        ojt_pkg::result_t res;
        logic [4:0]       count;
    } job_outcome_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [1:0]  action      = '0;
    logic [15:0] time_in     = '0;
    logic [7:0]  pickup      = '0;
    logic [7:0]  dropoff     = '0;
    logic [7:0]  item_type   = '0;
    logic [15:0] perish_time = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [1:0]  status;
    logic        found;
    logic [15:0] removed_time_in;
    logic [7:0]  removed_pickup;
    logic [7:0]  removed_dropoff;
    logic [7:0]  removed_item_type;
    logic [15:0] removed_perish_time;
    logic [4:0]  entry_count;

    job_req_t          pending_jobs[$];
    job_outcome_t      expected_results[$];
    ojt_pkg::job_rec_t recent_recs[$];

    ojt_pkg::job_rec_t shadow_recs[DEPTH];
    int       shadow_count   = 0;
    int       errors         = 0;
    int       cycles         = 0;
    int       gap_left       = 0;
    int       hold_left      = 0;
    int       results_taken  = 0;
    int       gen_index      = 0;
    bit       long_hold_done = 1'b0;
    bit       tail_phase     = 1'b0;

    ordered_job_table #(.TABLE_DEPTH(DEPTH)) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .action              (action),
        .time_in             (time_in),
        .pickup              (pickup),
        .dropoff             (dropoff),
        .item_type           (item_type),
        .perish_time         (perish_time),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .found               (found),
        .removed_time_in     (removed_time_in),
        .removed_pickup      (removed_pickup),
        .removed_dropoff     (removed_dropoff),
        .removed_item_type   (removed_item_type),
        .removed_perish_time (removed_perish_time),
        .entry_count         (entry_count)
    );

    always #5 clk = ~clk;

    task automatic table_apply(input job_req_t req, output job_outcome_t outcome);
        int hit;
        outcome = '0;
        outcome.res.status = ojt_pkg::STATUS_OK;
        case (req.act)
            ojt_pkg::ACT_APPEND:
            begin
                if (shadow_count >= DEPTH)
                    outcome.res.status = ojt_pkg::STATUS_FULL;
                else
                begin
                    shadow_recs[shadow_count] = req.rec;
                    shadow_count++;
                end
            end
            ojt_pkg::ACT_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < shadow_count; i++)
                    if (hit < 0 && shadow_recs[i].time_in == req.rec.time_in &&
                        shadow_recs[i].pickup == req.rec.pickup &&
                        shadow_recs[i].dropoff == req.rec.dropoff &&
                        shadow_recs[i].item_type == req.rec.item_type)
                        hit = i;
                if (hit < 0)
                    outcome.res.status = ojt_pkg::STATUS_NO_MATCH;
                else
                begin
                    outcome.res.rec = shadow_recs[hit];
                    for (int i = hit; i + 1 < shadow_count; i++)
                        shadow_recs[i] = shadow_recs[i + 1];
                    shadow_count--;
                end
            end
            ojt_pkg::ACT_QUERY:
            begin
                for (int i = 0; i < shadow_count; i++)
                    if (shadow_recs[i].pickup == req.rec.pickup)
                        outcome.res.found = 1'b1;
            end
            default: ;
        endcase
        outcome.count = 5'(shadow_count);
    endtask

    task automatic queue_job(input logic [1:0] act, input logic [15:0] t, input logic [7:0] p,
                             input logic [7:0] d, input logic [7:0] ty, input logic [15:0] pt);
        job_req_t j;
        j.act = act;
        j.rec.time_in = t;
        j.rec.pickup = p;
        j.rec.dropoff = d;
        j.rec.item_type = ty;
        j.rec.perish_time = pt;
        pending_jobs.push_back(j);
    endtask

    task automatic queue_random_jobs(input int n);
        job_req_t          j;
        ojt_pkg::job_rec_t r;
        int       roll;
        int       sub;
        int       pick;
        int       k;
        bit       filling;
        for (k = 0; k < n; k++)
        begin
            filling = ((gen_index / 80) % 2) == 0;
            gen_index++;
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0)
            begin
                r.time_in = 16'($urandom_range(0, 3));
                r.pickup = 8'($urandom_range(0, 3));
                r.dropoff = 8'($urandom_range(0, 1));
                r.item_type = 8'($urandom_range(0, 1));
            end
            else
            begin
                r.time_in = 16'($urandom);
                r.pickup = 8'($urandom);
                r.dropoff = 8'($urandom);
                r.item_type = 8'($urandom);
            end
            r.perish_time = 16'($urandom);
            j.rec = r;
            if (roll < 2)
                j.act = ACT_UNUSED;
            else if (roll < (filling ? 62 : 22))
            begin
                j.act = ojt_pkg::ACT_APPEND;
                recent_recs.push_back(r);
                if (recent_recs.size() > 40)
                    void'(recent_recs.pop_front());
            end
            else if (roll < 87)
            begin
                j.act = ojt_pkg::ACT_REMOVE;
                sub = $urandom_range(0, 99);
                if (recent_recs.size() > 0 && sub < 85)
                begin
                    pick = $urandom_range(0, recent_recs.size() - 1);
                    j.rec = recent_recs[pick];
                    j.rec.perish_time = 16'($urandom);
                    if (sub < 75)
                        recent_recs.delete(pick);
                    else
                        case ($urandom_range(0, 3))
                            0: j.rec.time_in ^= 16'(1 << $urandom_range(0, 15));
                            1: j.rec.pickup ^= 8'(1 << $urandom_range(0, 7));
                            2: j.rec.dropoff ^= 8'(1 << $urandom_range(0, 7));
                            default: j.rec.item_type ^= 8'(1 << $urandom_range(0, 7));
                        endcase
                end
            end
            else
            begin
                j.act = ojt_pkg::ACT_QUERY;
                if (recent_recs.size() > 0 && $urandom_range(0, 1) == 0)
                    j.rec.pickup = recent_recs[$urandom_range(0, recent_recs.size() - 1)].pickup;
            end
            pending_jobs.push_back(j);
        end
    endtask

    task automatic wait_drained();
        while (pending_jobs.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s wrong, expected %h actual %h", $time, label, want, got);
        end
    endtask

    // Driver: present the next pending transaction with random idle gaps, predict each one accepted.
    always @(posedge clk or negedge rst_n)
    begin : drive_jobs
        job_req_t     taken;
        job_req_t     nxt;
        job_outcome_t predicted;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken.act = action;
                taken.rec.time_in = time_in;
                taken.rec.pickup = pickup;
                taken.rec.dropoff = dropoff;
                taken.rec.item_type = item_type;
                taken.rec.perish_time = perish_time;
                table_apply(taken, predicted);
                expected_results.push_back(predicted);
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_jobs.size() > 0 && !tail_phase && $urandom_range(0, 11) == 0)
                begin
                    gap_left = $urandom_range(1, 19) - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_jobs.size() > 0)
                begin
                    nxt = pending_jobs.pop_front();
                    in_valid <= 1'b1;
                    action <= nxt.act;
                    time_in <= nxt.rec.time_in;
                    pickup <= nxt.rec.pickup;
                    dropoff <= nxt.rec.dropoff;
                    item_type <= nxt.rec.item_type;
                    perish_time <= nxt.rec.perish_time;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold to back up the table.
    always @(posedge clk or negedge rst_n)
    begin : receive_ctl
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                results_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && results_taken >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (!tail_phase && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(1, 19) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        job_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, status %h entry_count %h",
                         $time, status, entry_count);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 16'(want.res.status), 16'(status));
                check_field("found", 16'(want.res.found), 16'(found));
                check_field("removed_time_in", want.res.rec.time_in, removed_time_in);
                check_field("removed_pickup", 16'(want.res.rec.pickup), 16'(removed_pickup));
                check_field("removed_dropoff", 16'(want.res.rec.dropoff),
                            16'(removed_dropoff));
                check_field("removed_item_type", 16'(want.res.rec.item_type),
                            16'(removed_item_type));
                check_field("removed_perish_time", want.res.rec.perish_time,
                            removed_perish_time);
                check_field("entry_count", 16'(want.count), 16'(entry_count));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_job(ojt_pkg::ACT_QUERY, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
        queue_job(ojt_pkg::ACT_REMOVE, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
        queue_job(ACT_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        queue_job(ojt_pkg::ACT_APPEND, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        queue_job(ojt_pkg::ACT_APPEND, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
        queue_job(ojt_pkg::ACT_APPEND, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h1234);
        queue_job(ojt_pkg::ACT_QUERY, 16'h0000, 8'hFF, 8'h00, 8'h00, 16'h0000);
        queue_job(ojt_pkg::ACT_QUERY, 16'hFFFF, 8'h7F, 8'hFF, 8'hFF, 16'hFFFF);
        queue_job(ojt_pkg::ACT_REMOVE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFE, 16'hFFFF);
        queue_job(ojt_pkg::ACT_REMOVE, 16'h0000, 8'h00, 8'h00, 8'h00, 16'hFFFF);
        for (int i = 0; i < 14; i++)
            queue_job(ojt_pkg::ACT_APPEND, 16'h0100 + 16'(i), 8'h10 + 8'(i), 8'h20 + 8'(i),
                      8'h30 + 8'(i), 16'hA000 + 16'(i));
        queue_job(ojt_pkg::ACT_APPEND, 16'h5555, 8'h55, 8'h55, 8'h55, 16'h5555);
        queue_job(ACT_UNUSED, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
        queue_job(ojt_pkg::ACT_REMOVE, 16'h010D, 8'h1D, 8'h2D, 8'h3D, 16'h0000);
        queue_job(ojt_pkg::ACT_REMOVE, 16'h0106, 8'h16, 8'h26, 8'h36, 16'h0000);
        queue_job(ojt_pkg::ACT_REMOVE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
        wait_drained();

        queue_random_jobs(RANDOM_ITEMS / 2);
        wait_drained();
        repeat (SETTLE) @(negedge clk);

        queue_random_jobs(RANDOM_ITEMS / 2 - TAIL_ITEMS);
        while (pending_jobs.size() != 0)
            @(negedge clk);
        tail_phase = 1'b1;
        queue_random_jobs(TAIL_ITEMS);
        wait_drained();
        repeat (SETTLE) @(negedge clk);

        if (errors == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
src/ojt_pkg.sv
src/ojt_store.sv
src/ojt_seq.sv
src/ordered_job_table.sv
sim/testbench.sv
